// ===== rtl/mi4_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and operation tables for the 4x4 matrix inverse.
// Used by mi4_lane, mi4_merge and matrix_inverse_4x4; depends on nothing.

package mi4_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int NUM_LANES = 4;
   localparam int NUM_STEPS = 28;
   localparam int STEP_W    = 5;
   localparam int PH_W      = 3;
   localparam int FILE_N    = 10;

   localparam logic [1:0] COL_LAST = 2'd3;
   localparam logic [3:0] COF_BASE = 4'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_ITER,
      ST_DIV_OUT,
      ST_IDENT
   } state_type;

   // sequencer to lanes
   typedef struct packed {
      logic              calc;
      logic [STEP_W-1:0] step;
      logic [PH_W-1:0]   ph;
      logic              div_load;
      logic              div_iter;
      logic [1:0]        col;
   } ctrl_type;

   // one multiply-accumulate step of a lane
   typedef struct packed {
      logic       clr;
      logic       neg;
      logic       x_file;
      logic [3:0] x_idx;
      logic [3:0] y_idx;
      logic       wr_file;
      logic       wr_det;
      logic [3:0] wr_idx;
   } op_type;

   // row pair of 2x2 minor j
   function automatic logic [1:0] pair_lo(input logic [2:0] j);
      logic [1:0] r;
      unique case (j) inside
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_hi(input logic [2:0] j);
      logic [1:0] r;
      unique case (j) inside
         3'd0:             r = 2'd1;
         3'd1, 3'd3:       r = 2'd2;
         default:          r = 2'd3;
      endcase
      return r;
   endfunction

   // minor used by term u of cofactor k
   function automatic logic [2:0] cof_minor(input logic [1:0] k, input logic [1:0] u);
      logic [2:0] r;
      unique case ({k, u})
         4'b00_00: r = 3'd5;
         4'b00_01: r = 3'd4;
         4'b00_10: r = 3'd3;
         4'b01_00: r = 3'd5;
         4'b01_01: r = 3'd2;
         4'b01_10: r = 3'd1;
         4'b10_00: r = 3'd4;
         4'b10_01: r = 3'd2;
         4'b10_10: r = 3'd0;
         4'b11_00: r = 3'd3;
         4'b11_01: r = 3'd1;
         4'b11_10: r = 3'd0;
         default:  r = 3'd0;
      endcase
      return r;
   endfunction

   // program of the lane that produces inverse row `row`:
   // steps 0..11 six minors, 12..23 four cofactors, 24..27 determinant
   function automatic op_type lane_op(input logic [1:0] row, input logic [STEP_W-1:0] step);
      op_type            op;
      logic [2:0]        j;
      logic [1:0]        lo;
      logic [1:0]        hi;
      logic [3:0]        c0;
      logic [3:0]        base;
      logic [STEP_W-1:0] t;
      logic [7:0]        k_mul;
      logic [1:0]        k;
      logic [STEP_W-1:0] u_full;
      logic [1:0]        u;
      logic [1:0]        e_off;
      op     = '0;
      c0     = row[1] ? 4'd0 : 4'd8;
      base   = {row[1], ~row[0], 2'b00};
      j      = step[3:1];
      lo     = pair_lo(j);
      hi     = pair_hi(j);
      t      = step - STEP_W'(12);
      k_mul  = 8'(t) * 8'd11;
      k      = k_mul[6:5];
      u_full = t - STEP_W'({k, 1'b0}) - STEP_W'(k);
      u      = u_full[1:0];
      e_off  = (u >= k) ? u + 2'd1 : u;
      if (step < STEP_W'(12)) begin
         op.clr     = ~step[0];
         op.neg     = step[0];
         op.x_idx   = step[0] ? c0 + {2'b00, hi} : c0 + {2'b00, lo};
         op.y_idx   = step[0] ? c0 + 4'd4 + {2'b00, lo} : c0 + 4'd4 + {2'b00, hi};
         op.wr_file = step[0];
         op.wr_idx  = {1'b0, j};
      end else if (step < STEP_W'(24)) begin
         op.clr     = (u == 2'd0);
         op.neg     = (u == 2'd1) ^ row[0] ^ k[0];
         op.x_file  = 1'b1;
         op.x_idx   = {1'b0, cof_minor(k, u)};
         op.y_idx   = base + {2'b00, e_off};
         op.wr_file = (u == 2'd2);
         op.wr_idx  = COF_BASE + {2'b00, k};
      end else begin
         op.clr    = (step[1:0] == 2'd0);
         op.x_file = 1'b1;
         op.x_idx  = COF_BASE + {2'b00, step[1:0]};
         op.y_idx  = {row, step[1:0]};
         op.wr_det = (step[1:0] == 2'd3);
      end
      return op;
   endfunction

endpackage

// ===== rtl/mi4_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
// No dependencies.

module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/mi4_lane.sv =====
`timescale 1ns / 1ps
// One lane: minors, cofactors, determinant and divider for one inverse row.
// Depends on mi4_pkg and mi4_ram.

module mi4_lane
   import mi4_pkg::*;
#(
   parameter int ROW        = 0,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic                    wr_en,
   input  logic [1:0]              wr_col,
   input  logic [4*ELEM_WIDTH-1:0] wr_data,
   output logic [ELEM_WIDTH-1:0]   quot,
   output logic                    det_zero
);

   localparam int E   = ELEM_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int CW  = 3 * E + 3;
   localparam int NCH = (CW + E - 1) / E;
   localparam int XW  = NCH * E;
   localparam int AW  = XW + E;
   localparam int DW  = 4 * E + 5;
   localparam int NW  = CW + 2 * F;
   localparam int RW  = (NW > DW + E + 1) ? NW : DW + E + 1;
   localparam int QW  = E + 1;
   localparam int CHW = $clog2(NCH);
   localparam int SHW = $clog2(AW);
   localparam logic [QW-1:0] HALF     = QW'(1) << (E - 1);
   localparam logic [E-1:0]  ELEM_MAX = {1'b0, {(E - 1){1'b1}}};
   localparam logic [E-1:0]  ELEM_MIN = {1'b1, {(E - 1){1'b0}}};

   op_type op;

   logic [4*E-1:0] ram_a;
   logic [4*E-1:0] ram_b;

   logic [CW-1:0]  file_ff [FILE_N];
   logic [3:0]     file_idx;
   logic [CW-1:0]  file_rd;
   logic [DW-1:0]  det_ff;

   logic [E-1:0]          elem_a;
   logic [XW-1:0]         x_full;
   logic [CHW-1:0]        mchunk;
   logic [CHW-1:0]        achunk;
   logic [E-1:0]          x_chunk;
   logic signed [E:0]     mul_a;
   logic signed [E-1:0]   mul_b;
   logic signed [2*E:0]   prod;
   logic signed [2*E:0]   prod_ff;
   logic [AW-1:0]         p_ext;
   logic [AW-1:0]         p_shift;
   logic [AW-1:0]         acc_base;
   logic [AW-1:0]         acc_ff;
   logic [AW-1:0]         acc_in;
   logic                  acc_on;
   logic                  op_end;

   logic [NW-1:0] num_s;
   logic [NW-1:0] num_mag;
   logic [DW-1:0] det_mag;
   logic [RW-1:0] rem_ff;
   logic [RW-1:0] rem_in;
   logic [RW-1:0] dsr_ff;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] quo_neg;
   logic          neg_ff;
   logic          ovf_ff;
   logic          ge;

   assign op = lane_op(2'(ROW), ctrl.step);

   // local copy of the matrix, one column per word
   mi4_ram #(
      .WIDTH(4 * E),
      .DEPTH(4)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_col),
      .wr_data  (wr_data),
      .rd_addr_a(op.x_idx[3:2]),
      .rd_data_a(ram_a),
      .rd_addr_b(op.y_idx[3:2]),
      .rd_data_b(ram_b)
   );

   // operand selection
   assign file_idx = ctrl.calc ? op.x_idx : COF_BASE + {2'b00, ctrl.col};
   assign file_rd  = file_ff[file_idx];
   assign elem_a   = ram_a[E*op.x_idx[1:0] +: E];
   assign x_full   = op.x_file ? {{(XW - CW){file_rd[CW-1]}}, file_rd}
                               : {{(XW - E){elem_a[E-1]}}, elem_a};

   // one chunk of x times the element y per cycle
   assign mchunk  = CHW'(ctrl.ph - PH_W'(1));
   assign x_chunk = x_full[E*mchunk +: E];
   assign mul_a   = {(mchunk == CHW'(NCH - 1)) & x_chunk[E-1], x_chunk};
   assign mul_b   = ram_b[E*op.y_idx[1:0] +: E];
   assign prod    = mul_a * mul_b;

   // shifted accumulate of the registered partial product
   assign achunk   = CHW'(ctrl.ph - PH_W'(2));
   assign p_ext    = {{(AW - 2*E - 1){prod_ff[2*E]}}, prod_ff};
   assign p_shift  = p_ext << (SHW'(achunk) * SHW'(E));
   assign acc_base = (op.clr && ctrl.ph == PH_W'(2)) ? '0 : acc_ff;
   assign acc_in   = op.neg ? acc_base - p_shift : acc_base + p_shift;
   assign acc_on   = ctrl.calc && ctrl.ph >= PH_W'(2);
   assign op_end   = ctrl.calc && ctrl.ph == PH_W'(NCH + 1);

   always_ff @(posedge clock) begin
      prod_ff <= prod;
      if (acc_on) begin
         acc_ff <= acc_in;
      end
      if (op_end && op.wr_file) begin
         file_ff[op.wr_idx] <= acc_in[CW-1:0];
      end
      if (op_end && op.wr_det) begin
         det_ff <= acc_in[DW-1:0];
      end
   end

   assign det_zero = (det_ff == '0);

   // divider operands: cofactor scaled by two fraction widths over determinant
   assign num_s   = {{(NW - CW){file_rd[CW-1]}}, file_rd} << (2 * F);
   assign num_mag = num_s[NW-1] ? -num_s : num_s;
   assign det_mag = det_ff[DW-1] ? -det_ff : det_ff;

   // restoring division, one quotient bit per cycle
   assign ge     = (rem_ff >= dsr_ff);
   assign rem_in = ge ? rem_ff - dsr_ff : rem_ff;

   always_ff @(posedge clock) begin
      if (ctrl.div_load) begin
         rem_ff <= RW'(num_mag);
         dsr_ff <= RW'(det_mag) << E;
         quo_ff <= '0;
         neg_ff <= num_s[NW-1] ^ det_ff[DW-1];
         ovf_ff <= RW'(num_mag) >= (RW'(det_mag) << QW);
      end else if (ctrl.div_iter) begin
         rem_ff <= rem_in;
         dsr_ff <= dsr_ff >> 1;
         quo_ff <= {quo_ff[QW-2:0], ge};
      end
   end

   // sign and saturation
   assign quo_neg = -quo_ff;

   always_comb begin
      if (neg_ff) begin
         quot = (ovf_ff || quo_ff > HALF) ? ELEM_MIN : quo_neg[E-1:0];
      end else begin
         quot = (ovf_ff || quo_ff >= HALF) ? ELEM_MAX : quo_ff[E-1:0];
      end
   end

endmodule

// ===== rtl/mi4_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: gathers the four lane quotients, or the identity, into one result column.
// Depends on mi4_pkg.

module mi4_merge
   import mi4_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            capture,
   input  logic                            ident,
   input  logic [1:0]                      col,
   input  logic [NUM_LANES*ELEM_WIDTH-1:0] lane_quot,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_out_column,
   output logic signed [ELEM_WIDTH-1:0]    rsp_out_row0,
   output logic signed [ELEM_WIDTH-1:0]    rsp_out_row1,
   output logic signed [ELEM_WIDTH-1:0]    rsp_out_row2,
   output logic signed [ELEM_WIDTH-1:0]    rsp_out_row3,
   output logic                            rsp_singular,
   output logic                            rsp_last
);

   localparam int E = ELEM_WIDTH;
   localparam int F = FRAC_BITS;
   localparam logic [E-1:0] ELEM_MAX = {1'b0, {(E - 1){1'b1}}};
   localparam logic [E-1:0] ONE_VAL  = (F < E - 1) ? (E'(1) << F) : ELEM_MAX;

   logic          valid_ff;
   logic [1:0]    col_ff;
   logic          sing_ff;
   logic [E-1:0]  rows_ff [NUM_LANES];

   // strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= capture;
      end
   end

   // result column
   always_ff @(posedge clock) begin
      if (capture) begin
         col_ff  <= col;
         sing_ff <= ident;
         for (int r = 0; r < NUM_LANES; r++) begin
            if (ident) begin
               rows_ff[r] <= (col == 2'(r)) ? ONE_VAL : '0;
            end else begin
               rows_ff[r] <= lane_quot[r*E +: E];
            end
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_column = col_ff;
   assign rsp_out_row0   = rows_ff[0];
   assign rsp_out_row1   = rows_ff[1];
   assign rsp_out_row2   = rows_ff[2];
   assign rsp_out_row3   = rows_ff[3];
   assign rsp_singular   = sing_ff;
   assign rsp_last       = (col_ff == COL_LAST);

endmodule

// ===== rtl/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// Top level of the 4x4 fixed-point matrix inverse: sequencer, four lanes, merge.
// Depends on mi4_pkg, mi4_lane, mi4_merge.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   request  | req_column, req_row0..3                 | start high, busy low
//   result   | rsp_out_column, rsp_out_row0..3,        | rsp_valid, one cycle,
//            | rsp_singular, rsp_last                  | cannot be held off
//
// An item for columns 0 to 2 is stored and leaves busy low. An item for column 3 keeps busy high
// through the multiply-accumulate steps (NCH = 4 chunks per product through
// one (E+1)x E multiplier per lane), then, for each result column, through the
// restoring divider in each lane (ELEM_WIDTH+1 quotient bits). A singular matrix gives
// its four columns in consecutive cycles.
// Reset clears the sequencer and the result strobe; the stored matrix is not cleared.

module matrix_inverse_4x4
   import mi4_pkg::*;
#(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_column,
   input  logic signed [ELEM_WIDTH-1:0] req_row0,
   input  logic signed [ELEM_WIDTH-1:0] req_row1,
   input  logic signed [ELEM_WIDTH-1:0] req_row2,
   input  logic signed [ELEM_WIDTH-1:0] req_row3,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_out_column,
   output logic signed [ELEM_WIDTH-1:0] rsp_out_row0,
   output logic signed [ELEM_WIDTH-1:0] rsp_out_row1,
   output logic signed [ELEM_WIDTH-1:0] rsp_out_row2,
   output logic signed [ELEM_WIDTH-1:0] rsp_out_row3,
   output logic                         rsp_singular,
   output logic                         rsp_last
);

   localparam int E   = ELEM_WIDTH;
   localparam int CW  = 3 * E + 3;
   localparam int NCH = (CW + E - 1) / E;
   localparam int QW  = E + 1;
   localparam int IW  = $clog2(QW);

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [PH_W-1:0]   ph_ff;
   logic [PH_W-1:0]   ph_in;
   logic [1:0]        col_ff;
   logic [1:0]        col_in;
   logic [IW-1:0]     iter_ff;
   logic [IW-1:0]     iter_in;
   logic              capture;
   logic              ident;
   logic              accept;
   ctrl_type          ctrl;

   logic [NUM_LANES*E-1:0] lane_quot;
   logic [NUM_LANES-1:0]   lane_det_zero;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         ph_ff    <= '0;
         col_ff   <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         ph_ff    <= ph_in;
         col_ff   <= col_in;
         iter_ff  <= iter_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ph_in    = ph_ff;
      col_in   = col_ff;
      iter_in  = iter_ff;
      capture  = 1'b0;
      ident    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_column == COL_LAST) begin
               state_in = ST_CALC;
               step_in  = '0;
               ph_in    = '0;
            end
         end
         ST_CALC: begin
            if (ph_ff == PH_W'(NCH + 1)) begin
               ph_in = '0;
               if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
                  state_in = ST_CHECK;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end else begin
               ph_in = ph_ff + PH_W'(1);
            end
         end
         ST_CHECK: begin
            col_in   = '0;
            state_in = lane_det_zero[0] ? ST_IDENT : ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            iter_in  = '0;
            state_in = ST_DIV_ITER;
         end
         ST_DIV_ITER: begin
            if (iter_ff == IW'(QW - 1)) begin
               state_in = ST_DIV_OUT;
            end else begin
               iter_in = iter_ff + IW'(1);
            end
         end
         ST_DIV_OUT: begin
            capture  = 1'b1;
            col_in   = col_ff + 2'd1;
            state_in = (col_ff == COL_LAST) ? ST_IDLE : ST_DIV_LOAD;
         end
         ST_IDENT: begin
            capture = 1'b1;
            ident   = 1'b1;
            col_in  = col_ff + 2'd1;
            if (col_ff == COL_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // lane control
   assign ctrl.calc     = (state_ff == ST_CALC);
   assign ctrl.step     = step_ff;
   assign ctrl.ph       = ph_ff;
   assign ctrl.div_load = (state_ff == ST_DIV_LOAD);
   assign ctrl.div_iter = (state_ff == ST_DIV_ITER);
   assign ctrl.col      = col_ff;

   // one lane per inverse row
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      mi4_lane #(
         .ROW       (g),
         .ELEM_WIDTH(ELEM_WIDTH),
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .ctrl    (ctrl),
         .wr_en   (accept),
         .wr_col  (req_column),
         .wr_data ({req_row3, req_row2, req_row1, req_row0}),
         .quot    (lane_quot[g*E +: E]),
         .det_zero(lane_det_zero[g])
      );
   end

   // result column assembly
   mi4_merge #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .capture       (capture),
      .ident         (ident),
      .col           (col_ff),
      .lane_quot     (lane_quot),
      .rsp_valid     (rsp_valid),
      .rsp_out_column(rsp_out_column),
      .rsp_out_row0  (rsp_out_row0),
      .rsp_out_row1  (rsp_out_row1),
      .rsp_out_row2  (rsp_out_row2),
      .rsp_out_row3  (rsp_out_row3),
      .rsp_singular  (rsp_singular),
      .rsp_last      (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // a result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a running inversion");

   // every lane agrees on whether the determinant is zero
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (&lane_det_zero || !(|lane_det_zero)))
      else $error("lanes disagree on a zero determinant");

   // the last column ends the inversion
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("still busy after the last column");

   // identity columns come out in consecutive cycles
   a_col_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last && rsp_singular) |=> rsp_valid && rsp_singular)
      else $error("identity columns not consecutive");
`endif

endmodule
